FILE: rtl/core/lts_pkg.sv
package lts_pkg;

   localparam logic [4:0] K_EOF     = 5'd0;
   localparam logic [4:0] K_WORD    = 5'd1;
   localparam logic [4:0] K_QUOTED  = 5'd2;
   localparam logic [4:0] K_NUMBER  = 5'd3;
   localparam logic [4:0] K_COLON   = 5'd4;
   localparam logic [4:0] K_LBRACK  = 5'd5;
   localparam logic [4:0] K_RBRACK  = 5'd6;
   localparam logic [4:0] K_LPAREN  = 5'd7;
   localparam logic [4:0] K_RPAREN  = 5'd8;
   localparam logic [4:0] K_PLUS    = 5'd9;
   localparam logic [4:0] K_MINUS   = 5'd10;
   localparam logic [4:0] K_UNARY   = 5'd11;
   localparam logic [4:0] K_STAR    = 5'd12;
   localparam logic [4:0] K_SLASH   = 5'd13;
   localparam logic [4:0] K_EQUAL   = 5'd14;
   localparam logic [4:0] K_LESS    = 5'd15;
   localparam logic [4:0] K_GREATER = 5'd16;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_LE    = 8'h65;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_LN    = 8'h6E;
   localparam logic [7:0] CH_UN    = 8'h4E;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef enum logic [7:0] {
      M_IDLE    = 8'b0000_0001,
      M_COMMENT = 8'b0000_0010,
      M_MINUS   = 8'b0000_0100,
      M_QUOTED  = 8'b0000_1000,
      M_COLON   = 8'b0001_0000,
      M_WORD    = 8'b0010_0000,
      M_DIGIT   = 8'b0100_0000,
      M_NEGNUM  = 8'b1000_0000
   } mode_type;

   typedef enum logic [3:0] {
      F_NONE = 4'd0, F_DOTONLY = 4'd1, F_INT = 4'd2, F_FRAC = 4'd3,
      F_MARKE = 4'd4, F_MARKN = 4'd5, F_EXPD = 4'd6, F_BAD = 4'd7,
      F_SIGNP = 4'd8, F_SIGNM = 4'd9, F_SDIGP = 4'd10, F_SDIGM = 4'd11
   } form_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        space;
      logic [7:0]  newlines;
   } token_type;

   function automatic logic is_sp(input logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
   endfunction

   function automatic logic is_dg(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] c);
      case (c)
         8'h5B: return K_LBRACK;
         8'h5D: return K_RBRACK;
         8'h28: return K_LPAREN;
         8'h29: return K_RPAREN;
         8'h2B: return K_PLUS;
         8'h2A: return K_STAR;
         8'h2F: return K_SLASH;
         8'h3D: return K_EQUAL;
         8'h3C: return K_LESS;
         8'h3E: return K_GREATER;
         default: return K_EOF;
      endcase
   endfunction

   function automatic logic is_dl(input logic [7:0] c);
      return c == CH_DASH || single_kind(c) != K_EOF;
   endfunction

   function automatic form_type next_form(input form_type f, input logic [7:0] c);
      if (is_dg(c)) begin
         if (f == F_NONE || f == F_INT) return F_INT;
         if (f == F_DOTONLY || f == F_FRAC) return F_FRAC;
         if (f == F_MARKE || f == F_MARKN || f == F_EXPD) return F_EXPD;
         return F_BAD;
      end
      if (c == CH_DOT) begin
         if (f == F_NONE) return F_DOTONLY;
         if (f == F_INT) return F_FRAC;
         return F_BAD;
      end
      if (c == CH_LE || c == CH_UE) return (f == F_INT || f == F_FRAC) ? F_MARKE : F_BAD;
      if (c == CH_LN || c == CH_UN) return (f == F_INT || f == F_FRAC) ? F_MARKN : F_BAD;
      return F_BAD;
   endfunction

   function automatic logic [4:0] form_kind(input form_type f);
      return (f == F_INT || f == F_FRAC || f == F_EXPD) ? K_NUMBER : K_WORD;
   endfunction

endpackage

FILE: rtl/core/lts_scan.sv
// Scan core: one character updates the scan state and yields up to four tokens.
// The passes of the model unroll into at most three short re-dispatch steps.
module lts_scan #(
   parameter int PB = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              char_code,
   input  logic                    end_of_text,
   output lts_pkg::token_type [3:0] tokens,
   output logic [2:0]              count
);

   lts_pkg::mode_type mode_ff, mode_in;
   lts_pkg::form_type form_ff, form_in;
   logic [PB-1:0] origin_ff, origin_in, pos_ff, pos_in, esoff_ff, esoff_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic          esc_ff, esc_in, faq_ff, faq_in, spc_ff, spc_in;
   logic [4:0]    prior_ff, prior_in;
   logic [7:0]    nl_ff, nl_in;

   function automatic logic prior_delim(input logic [4:0] k);
      return k == lts_pkg::K_EOF || k == lts_pkg::K_LBRACK || k == lts_pkg::K_LPAREN ||
             (k >= lts_pkg::K_PLUS && k <= lts_pkg::K_GREATER);
   endfunction

   always_comb begin
      logic [7:0] c;
      logic       done, unary, plus, digs, isend;
      logic [PB-1:0] signpos;
      logic [4:0] k;
      c = char_code;
      isend = end_of_text || c == 8'h00;
      mode_in = mode_ff; form_in = form_ff; origin_in = origin_ff; cnt_in = cnt_ff;
      esoff_in = esoff_ff; esc_in = esc_ff; faq_in = faq_ff; prior_in = prior_ff;
      spc_in = spc_ff; nl_in = nl_ff; pos_in = pos_ff;
      tokens = '0; count = 3'd0;
      done = 1'b0; unary = 1'b0; plus = 1'b0; digs = 1'b0; signpos = '0;
      k = lts_pkg::K_EOF;

      if (isend) begin
         case (mode_in)
            lts_pkg::M_MINUS: begin
               k = (!spc_in && prior_delim(prior_in)) ? lts_pkg::K_UNARY : lts_pkg::K_MINUS;
               tokens[count[1:0]] = '{k, 16'(origin_in), 16'd1, spc_in, nl_in};
               count = count + 3'd1; spc_in = 1'b0; nl_in = '0;
            end
            lts_pkg::M_QUOTED, lts_pkg::M_COLON, lts_pkg::M_WORD,
            lts_pkg::M_NEGNUM: begin
               k = (mode_in == lts_pkg::M_QUOTED) ? lts_pkg::K_QUOTED :
                   (mode_in == lts_pkg::M_COLON) ? lts_pkg::K_COLON :
                   (mode_in == lts_pkg::M_NEGNUM) ? lts_pkg::K_NUMBER :
                   lts_pkg::form_kind(form_in);
               tokens[count[1:0]] = '{k, 16'(origin_in), cnt_in, spc_in, nl_in};
               count = count + 3'd1; spc_in = 1'b0; nl_in = '0;
            end
            lts_pkg::M_DIGIT: begin
               if (form_in == lts_pkg::F_SDIGP || form_in == lts_pkg::F_SDIGM) begin
                  tokens[count[1:0]] = '{lts_pkg::K_NUMBER, 16'(origin_in), cnt_in,
                                         spc_in, nl_in};
                  count = count + 3'd1; spc_in = 1'b0; nl_in = '0;
               end else if (form_in >= lts_pkg::F_SIGNP) begin
                  plus = form_in == lts_pkg::F_SIGNP;
                  signpos = origin_in + esoff_in;
                  tokens[count[1:0]] = '{lts_pkg::K_WORD, 16'(origin_in), 16'(esoff_in),
                                         spc_in, nl_in};
                  tokens[count[1:0]+2'd1] = '{plus ? lts_pkg::K_PLUS : lts_pkg::K_MINUS,
                                              16'(signpos), 16'd1, 1'b0, 8'd0};
                  count = count + 3'd2; spc_in = 1'b0; nl_in = '0;
               end else begin
                  tokens[count[1:0]] = '{lts_pkg::form_kind(form_in), 16'(origin_in),
                                         cnt_in, spc_in, nl_in};
                  count = count + 3'd1; spc_in = 1'b0; nl_in = '0;
               end
            end
            default: ;
         endcase
         tokens[count[1:0]] = '{lts_pkg::K_EOF, 16'(pos_ff), 16'd0, spc_in, nl_in};
         count = count + 3'd1;
         mode_in = lts_pkg::M_IDLE; form_in = lts_pkg::F_NONE; origin_in = '0;
         cnt_in = '0; esoff_in = '0; esc_in = 1'b0; faq_in = 1'b0;
         prior_in = lts_pkg::K_EOF; spc_in = 1'b0; nl_in = '0; pos_in = '0;
      end else begin
         pos_in = pos_ff + 1'b1;
         for (int p = 0; p < 4; p++) begin
            if (!done) begin
               done = 1'b1;
               case (mode_in)
                  lts_pkg::M_IDLE: begin
                     k = lts_pkg::single_kind(c);
                     if (lts_pkg::is_sp(c)) begin
                        spc_in = 1'b1;
                        if (c == lts_pkg::CH_LF && nl_in != 8'hFF) nl_in = nl_in + 8'd1;
                     end else if (c == lts_pkg::CH_SEMI) begin
                        spc_in = 1'b1; mode_in = lts_pkg::M_COMMENT;
                     end else if (k != lts_pkg::K_EOF) begin
                        tokens[count[1:0]] = '{k, 16'(pos_ff), 16'd1, spc_in, nl_in};
                        count = count + 3'd1; spc_in = 1'b0; nl_in = '0; prior_in = k;
                     end else begin
                        origin_in = pos_ff; cnt_in = 16'd1; esc_in = 1'b0;
                        if (c == lts_pkg::CH_DASH) mode_in = lts_pkg::M_MINUS;
                        else if (c == lts_pkg::CH_QUOTE) begin
                           mode_in = lts_pkg::M_QUOTED; faq_in = 1'b1;
                        end else if (c == lts_pkg::CH_COLON) mode_in = lts_pkg::M_COLON;
                        else if (lts_pkg::is_dg(c)) begin
                           mode_in = lts_pkg::M_DIGIT; form_in = lts_pkg::F_INT;
                        end else begin
                           mode_in = lts_pkg::M_WORD;
                           if (c == lts_pkg::CH_BSL) begin
                              esc_in = 1'b1; form_in = lts_pkg::F_BAD;
                           end else form_in = lts_pkg::next_form(lts_pkg::F_NONE, c);
                        end
                     end
                  end
                  lts_pkg::M_COMMENT: begin
                     if (c == lts_pkg::CH_LF) begin
                        mode_in = lts_pkg::M_IDLE; done = 1'b0;
                     end
                  end
                  lts_pkg::M_MINUS: begin
                     unary = spc_in ? !lts_pkg::is_sp(c) : prior_delim(prior_in);
                     if (unary && lts_pkg::is_dg(c)) begin
                        mode_in = lts_pkg::M_NEGNUM; form_in = lts_pkg::F_INT;
                        if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                     end else begin
                        k = unary ? lts_pkg::K_UNARY : lts_pkg::K_MINUS;
                        tokens[count[1:0]] = '{k, 16'(origin_in), 16'd1, spc_in, nl_in};
                        count = count + 3'd1; spc_in = 1'b0; nl_in = '0; prior_in = k;
                        mode_in = lts_pkg::M_IDLE; done = 1'b0;
                     end
                  end
                  lts_pkg::M_QUOTED: begin
                     if (esc_in) begin
                        esc_in = 1'b0;
                        if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                     end else if (c == lts_pkg::CH_BSL) begin
                        esc_in = 1'b1; faq_in = 1'b0;
                        if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                     end else if (c == 8'h5B || c == 8'h5D || lts_pkg::is_sp(c) ||
                                  (!faq_in && lts_pkg::is_dl(c) &&
                                   c != lts_pkg::CH_SLASH)) begin
                        tokens[count[1:0]] = '{lts_pkg::K_QUOTED, 16'(origin_in), cnt_in,
                                               spc_in, nl_in};
                        count = count + 3'd1; spc_in = 1'b0; nl_in = '0;
                        prior_in = lts_pkg::K_QUOTED;
                        mode_in = lts_pkg::M_IDLE; done = 1'b0;
                     end else begin
                        faq_in = 1'b0;
                        if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                     end
                  end
                  lts_pkg::M_COLON, lts_pkg::M_WORD, lts_pkg::M_DIGIT: begin
                     plus = form_in == lts_pkg::F_SIGNP || form_in == lts_pkg::F_SDIGP;
                     digs = form_in == lts_pkg::F_SDIGP || form_in == lts_pkg::F_SDIGM;
                     if (esc_in) begin
                        esc_in = 1'b0;
                        if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                     end else if (mode_in == lts_pkg::M_DIGIT &&
                                  form_in >= lts_pkg::F_SIGNP) begin
                        if (lts_pkg::is_dg(c)) begin
                           form_in = plus ? lts_pkg::F_SDIGP : lts_pkg::F_SDIGM;
                           if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                        end else if (digs && (lts_pkg::is_sp(c) || lts_pkg::is_dl(c))) begin
                           tokens[count[1:0]] = '{lts_pkg::K_NUMBER, 16'(origin_in), cnt_in,
                                                  spc_in, nl_in};
                           count = count + 3'd1; spc_in = 1'b0; nl_in = '0;
                           prior_in = lts_pkg::K_NUMBER;
                           mode_in = lts_pkg::M_IDLE; done = 1'b0;
                        end else begin
                           // Failed exponent: split into word, sign and rest.
                           signpos = origin_in + esoff_in;
                           tokens[count[1:0]] = '{lts_pkg::K_WORD, 16'(origin_in),
                                                  16'(esoff_in), spc_in, nl_in};
                           k = plus ? lts_pkg::K_PLUS : lts_pkg::K_MINUS;
                           tokens[count[1:0]+2'd1] = '{k, 16'(signpos), 16'd1, 1'b0, 8'd0};
                           count = count + 3'd2; spc_in = 1'b0; nl_in = '0; prior_in = k;
                           if (digs) begin
                              origin_in = signpos + 1'b1;
                              cnt_in = (cnt_in == 16'hFFFF) ? 16'hFFFF :
                                       cnt_in - 16'(esoff_in) - 16'd1;
                              form_in = lts_pkg::F_INT; esc_in = 1'b0;
                              mode_in = lts_pkg::M_DIGIT;
                           end else mode_in = lts_pkg::M_IDLE;
                           done = 1'b0;
                        end
                     end else if (c == lts_pkg::CH_BSL) begin
                        esc_in = 1'b1; form_in = lts_pkg::F_BAD;
                        if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                     end else if (mode_in == lts_pkg::M_DIGIT &&
                                  form_in == lts_pkg::F_MARKE &&
                                  (c == lts_pkg::CH_PLUS || c == lts_pkg::CH_DASH)) begin
                        esoff_in = PB'(cnt_in);
                        form_in = (c == lts_pkg::CH_PLUS) ? lts_pkg::F_SIGNP : lts_pkg::F_SIGNM;
                        if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                     end else if (lts_pkg::is_sp(c) || lts_pkg::is_dl(c) ||
                                  c == lts_pkg::CH_SEMI) begin
                        k = (mode_in == lts_pkg::M_COLON) ? lts_pkg::K_COLON :
                            lts_pkg::form_kind(form_in);
                        tokens[count[1:0]] = '{k, 16'(origin_in), cnt_in, spc_in, nl_in};
                        count = count + 3'd1; spc_in = 1'b0; nl_in = '0; prior_in = k;
                        mode_in = lts_pkg::M_IDLE; done = 1'b0;
                     end else begin
                        form_in = lts_pkg::next_form(form_in, c);
                        if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                     end
                  end
                  lts_pkg::M_NEGNUM: begin
                     if (form_in == lts_pkg::F_MARKE &&
                         (c == lts_pkg::CH_PLUS || c == lts_pkg::CH_DASH)) begin
                        form_in = lts_pkg::F_INT;
                        if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                     end else if (lts_pkg::is_dg(c) || c == lts_pkg::CH_DOT ||
                                  c == lts_pkg::CH_LE || c == lts_pkg::CH_UE ||
                                  c == lts_pkg::CH_LN || c == lts_pkg::CH_UN) begin
                        form_in = (c == lts_pkg::CH_LE || c == lts_pkg::CH_UE) ?
                                  lts_pkg::F_MARKE : lts_pkg::F_INT;
                        if (cnt_in != 16'hFFFF) cnt_in = cnt_in + 16'd1;
                     end else begin
                        tokens[count[1:0]] = '{lts_pkg::K_NUMBER, 16'(origin_in), cnt_in,
                                               spc_in, nl_in};
                        count = count + 3'd1; spc_in = 1'b0; nl_in = '0;
                        prior_in = lts_pkg::K_NUMBER;
                        mode_in = lts_pkg::M_IDLE; done = 1'b0;
                     end
                  end
                  default: begin
                     mode_in = lts_pkg::M_IDLE; done = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lts_pkg::M_IDLE; form_ff <= lts_pkg::F_NONE; origin_ff <= '0;
         cnt_ff <= '0; esoff_ff <= '0; esc_ff <= 1'b0; faq_ff <= 1'b0;
         prior_ff <= lts_pkg::K_EOF; spc_ff <= 1'b0; nl_ff <= '0; pos_ff <= '0;
      end else if (step) begin
         mode_ff <= mode_in; form_ff <= form_in; origin_ff <= origin_in;
         cnt_ff <= cnt_in; esoff_ff <= esoff_in; esc_ff <= esc_in; faq_ff <= faq_in;
         prior_ff <= prior_in; spc_ff <= spc_in; nl_ff <= nl_in; pos_ff <= pos_in;
      end
   end

`ifndef ASSERT_OFF
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(mode_ff))
      else $error("scan mode not one-hot");
   a_count: assert property (@(posedge clock) disable iff (reset)
      step && end_of_text |-> count != 3'd0)
      else $error("end of text produced no token");
   a_endclr: assert property (@(posedge clock) disable iff (reset)
      step && end_of_text |=> pos_ff == '0)
      else $error("position not cleared at end of text");
`endif

endmodule

FILE: rtl/core/lts_outq.sv
// Result stage: holds one character's tokens, hands out one a cycle while rsp_ready.
module lts_outq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  lts_pkg::token_type [3:0] load_tokens,
   input  logic [2:0]              load_count,
   output logic                    empty_next,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lts_pkg::token_type      rsp_token,
   output logic                    rsp_last
);

   lts_pkg::token_type [3:0] tok_ff;
   logic [2:0] left_ff, left_in;
   logic [1:0] idx_ff, idx_in;
   logic       pop;

   assign rsp_valid = left_ff != 3'd0;
   assign pop = rsp_valid && rsp_ready;
   assign rsp_token = tok_ff[idx_ff];
   assign rsp_last = left_ff == 3'd1;
   // Free for a new load when empty or when the final token leaves now.
   assign empty_next = left_ff == 3'd0 || (pop && left_ff == 3'd1);

   always_comb begin
      left_in = left_ff; idx_in = idx_ff;
      if (pop) begin
         left_in = left_ff - 3'd1; idx_in = idx_ff + 2'd1;
      end
      if (load) begin
         left_in = load_count; idx_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0; idx_ff <= '0;
      end else begin
         left_ff <= left_in; idx_ff <= idx_in;
      end
      if (load) tok_ff <= load_tokens;
   end

`ifndef ASSERT_OFF
   a_noload: assert property (@(posedge clock) disable iff (reset)
      load |-> empty_next)
      else $error("load while tokens pending");
   a_max: assert property (@(posedge clock) disable iff (reset) left_ff <= 3'd4)
      else $error("queue count out of range");
`endif

endmodule

FILE: rtl/core/logo_token_scanner_top.sv
// A request's first token is offered in the cycle after acceptance.
// Throughput: one character per cycle when it yields at most one token and the
// receiver is ready; with more tokens the input waits while the result stage drains.
// Reset: synchronous, active high; clears the scan state and the result queue.
// End of text flushes the pending token, emits EOF and returns to the reset state.
module logo_token_scanner_top #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_space_before,
   output logic        rsp_newline_before,
   output logic [7:0]  rsp_newlines_seen,
   output logic        rsp_last
);

   lts_pkg::token_type [3:0] tokens;
   lts_pkg::token_type       tok;
   logic [2:0] count;
   logic       step, empty_next;

   // A request is taken whenever the result stage frees up in this cycle.
   assign req_ready = empty_next;
   assign step = req_valid && req_ready;

   lts_scan #(.PB(POSITION_BITS)) u_scan (
      .clock, .reset, .step,
      .char_code(req_char_code), .end_of_text(req_end_of_text),
      .tokens, .count
   );

   // Requests that produce no tokens leave the queue empty.
   lts_outq u_outq (
      .clock, .reset, .load(step), .load_tokens(tokens), .load_count(count),
      .empty_next, .rsp_valid, .rsp_ready, .rsp_token(tok), .rsp_last
   );

   assign rsp_token_kind     = tok.kind;
   assign rsp_token_start    = tok.start;
   assign rsp_token_length   = tok.length;
   assign rsp_space_before   = tok.space;
   assign rsp_newline_before = tok.newlines != 8'd0;
   assign rsp_newlines_seen  = tok.newlines;

`ifndef ASSERT_OFF
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_token_kind <= lts_pkg::K_GREATER)
      else $error("token kind out of range");
   a_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == lts_pkg::K_EOF |-> rsp_last)
      else $error("EOF not final");
   a_nlflag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_newline_before |-> rsp_space_before)
      else $error("newline without space flag");
`endif

endmodule
